>>> rtl/ttlhc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttlhc_pkg
// Shared constants and types for the TTL hash decision cache.
// ----------------------------------------------------------------------------
package ttlhc_pkg;

    localparam int SLOTS    = 64;
    localparam int KEY_BITS = 64;
    localparam int A_W      = $clog2(SLOTS);

    // command codes
    localparam logic [2:0] CMD_LOOKUP = 3'd0;
    localparam logic [2:0] CMD_STORE  = 3'd1;
    localparam logic [2:0] CMD_SWEEP  = 3'd2;
    localparam logic [2:0] CMD_CLEAR  = 3'd3;
    localparam logic [2:0] CMD_STATS  = 3'd4;

    typedef struct packed {
        logic [31:0]         hash;
        logic [KEY_BITS-1:0] key;
        logic                dec;
        logic [63:0]         tstamp;
    } t_entry;

    // write-side controls from the sequencer to the table
    typedef struct packed {
        logic           wr_en;
        logic [A_W-1:0] wr_addr;
        logic           inv_en;
        logic [A_W-1:0] inv_addr;
        logic           clr_all;
    } t_tbl_ctl;

endpackage

>>> rtl/ttl_hash_decision_cache.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttl_hash_decision_cache
// Linear-probe hash cache of decision bits with time-to-live expiry.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; exactly one result
// follows, shown for one cycle with o_valid high, and it must be taken then.
// The slot memory is read once per cycle: lookup and store read one probed
// slot after another until they finish, sweep and statistics read every
// slot, while a sweep at time zero, clear and unknown commands finish on the
// first read. The next request may be issued in the cycle the result is shown.
// Reset and clear empty the table at once.
module ttl_hash_decision_cache import ttlhc_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [31:0]         i_cfg_data,
    input  logic                start,
    output logic                busy,
    input  logic [2:0]          i_cmd,
    input  logic [63:0]         i_path_key,
    input  logic [31:0]         i_path_hash,
    input  logic                i_decision_in,
    input  logic [63:0]         i_now_ms,
    output logic                o_valid,
    output logic                o_hit,
    output logic                o_decision_out,
    output logic [31:0]         o_hit_total,
    output logic [31:0]         o_miss_total,
    output logic [6:0]          o_used_count,
    output logic [6:0]          o_expired_count
);

    typedef enum logic {S_IDLE, S_RUN} t_state;

    t_state              r_state;
    logic [31:0]         r_ttl;
    logic [2:0]          r_cmd;
    logic [KEY_BITS-1:0] r_key;
    logic [31:0]         r_hash;
    logic                r_dec;
    logic [63:0]         r_now;
    logic [A_W-1:0]      r_start;
    logic [A_W-1:0]      r_addr;
    logic [A_W-1:0]      r_p;
    logic [6:0]          r_used;
    logic [6:0]          r_exp;
    logic [31:0]         r_hits;
    logic [31:0]         r_miss;

    t_entry         rd_e;
    t_entry         wr_e;
    t_tbl_ctl       ctl;
    logic [A_W-1:0] rd_addr;
    logic [A_W-1:0] addr_nx;
    logic           accept;
    logic           is_used;
    logic           is_match;
    logic           is_exp;
    logic           last;
    logic           fin;
    logic           hit_n;
    logic           miss_n;
    logic [6:0]     used_n;
    logic [6:0]     exp_n;
    logic [63:0]    age;

    assign accept = start && (r_state == S_IDLE);
    assign busy   = (r_state != S_IDLE);

    ttlhc_table u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (rd_addr),
        .i_ctl     (ctl),
        .i_wr_data (wr_e),
        .o_rd_data (rd_e)
    );

    // slot tests on the entry read this cycle
    assign age      = r_now - rd_e.tstamp;
    assign is_used  = (rd_e.hash != '0);
    assign is_match = (rd_e.hash == r_hash) && (rd_e.key == r_key);
    assign is_exp   = (r_now != '0) && (rd_e.tstamp != '0) && (age > {32'd0, r_ttl});
    assign last     = (r_p == A_W'(SLOTS - 1));
    assign addr_nx  = (r_addr == A_W'(SLOTS - 1)) ? '0 : r_addr + 1'b1;

    // read address: first slot at accept, next slot while running
    always_comb begin
        if (r_state == S_IDLE) begin
            if (i_cmd == CMD_LOOKUP || i_cmd == CMD_STORE) begin
                rd_addr = A_W'(i_path_hash % SLOTS);
            end else begin
                rd_addr = '0;
            end
        end else begin
            rd_addr = addr_nx;
        end
    end

    // per-probe decision
    always_comb begin
        fin          = 1'b0;
        hit_n        = 1'b0;
        miss_n       = 1'b0;
        used_n       = r_used;
        exp_n        = r_exp;
        ctl          = '0;
        ctl.wr_addr  = r_addr;
        ctl.inv_addr = r_addr;
        wr_e.hash    = r_hash;
        wr_e.key     = r_key;
        wr_e.dec     = r_dec;
        wr_e.tstamp  = r_now;
        if (r_state == S_RUN) begin
            unique case (r_cmd)
                CMD_LOOKUP: begin
                    if (!is_used) begin
                        fin    = 1'b1;
                        miss_n = 1'b1;
                    end else if (is_match) begin
                        fin = 1'b1;
                        if (is_exp) begin
                            ctl.inv_en = 1'b1;
                            miss_n     = 1'b1;
                        end else begin
                            hit_n = 1'b1;
                        end
                    end else begin
                        ctl.inv_en = is_exp;
                        if (last) begin
                            fin    = 1'b1;
                            miss_n = 1'b1;
                        end
                    end
                end
                CMD_STORE: begin
                    if (!is_used || is_exp || is_match) begin
                        fin       = 1'b1;
                        ctl.wr_en = 1'b1;
                    end else if (last) begin
                        fin         = 1'b1;
                        ctl.wr_en   = 1'b1;
                        ctl.wr_addr = r_start;
                    end
                end
                CMD_SWEEP: begin
                    ctl.inv_en = is_used && is_exp;
                    fin        = last || (r_now == '0);
                end
                CMD_STATS: begin
                    if (is_used) begin
                        if (r_used != 7'h7F) used_n = r_used + 1'b1;
                        if (is_exp && r_exp != 7'h7F) exp_n = r_exp + 1'b1;
                    end
                    fin = last;
                end
                CMD_CLEAR: begin
                    ctl.clr_all = 1'b1;
                    fin         = 1'b1;
                end
                default: begin
                    fin = 1'b1;
                end
            endcase
        end
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ttl <= '0;
        end else if (i_cfg_we) begin
            r_ttl <= i_cfg_data;
        end
    end

    // sequencer, counters and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_hits  <= '0;
            r_miss  <= '0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_RUN;
                        r_cmd   <= i_cmd;
                        r_key   <= i_path_key[KEY_BITS-1:0];
                        r_hash  <= i_path_hash;
                        r_dec   <= i_decision_in;
                        r_now   <= i_now_ms;
                        r_start <= rd_addr;
                        r_addr  <= rd_addr;
                        r_p     <= '0;
                        r_used  <= '0;
                        r_exp   <= '0;
                    end
                end
                S_RUN: begin
                    r_addr <= addr_nx;
                    r_p    <= r_p + 1'b1;
                    r_used <= used_n;
                    r_exp  <= exp_n;
                    if (fin) begin
                        r_state        <= S_IDLE;
                        o_valid        <= 1'b1;
                        o_hit          <= hit_n;
                        o_decision_out <= hit_n & rd_e.dec;
                        o_used_count   <= (r_cmd == CMD_STATS) ? used_n : '0;
                        o_expired_count <= (r_cmd == CMD_STATS) ? exp_n : '0;
                        if (r_cmd == CMD_CLEAR) begin
                            r_hits       <= '0;
                            r_miss       <= '0;
                            o_hit_total  <= '0;
                            o_miss_total <= '0;
                        end else begin
                            if (hit_n && r_hits != '1) r_hits <= r_hits + 1'b1;
                            if (miss_n && r_miss != '1) r_miss <= r_miss + 1'b1;
                            o_hit_total  <= (hit_n && r_hits != '1) ? r_hits + 1'b1 : r_hits;
                            o_miss_total <= (miss_n && r_miss != '1) ? r_miss + 1'b1 : r_miss;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

>>> rtl/ttlhc_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttlhc_table
// Slot memory with a registered read and a valid bit per slot.
// ----------------------------------------------------------------------------
module ttlhc_table import ttlhc_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [A_W-1:0] i_rd_addr,
    input  t_tbl_ctl       i_ctl,
    input  t_entry         i_wr_data,
    output t_entry         o_rd_data
);

    t_entry           r_mem [SLOTS];
    logic [SLOTS-1:0] r_valid;
    t_entry           r_rd;
    logic             r_rd_vld;

    // memory array
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_ctl.wr_addr] <= i_wr_data;
        end
        r_rd <= r_mem[i_rd_addr];
    end

    // valid bits: invalid slot reads as all zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clr_all) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= r_valid[i_rd_addr];
            if (i_ctl.wr_en) begin
                r_valid[i_ctl.wr_addr] <= 1'b1;
            end
            if (i_ctl.inv_en) begin
                r_valid[i_ctl.inv_addr] <= 1'b0;
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd : '0;

endmodule

>>> rtl/ttlhc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttlhc_checker
// Port-level checks for the TTL hash decision cache.
// ----------------------------------------------------------------------------
module ttlhc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_valid,
    input logic        o_hit,
    input logic        o_decision_out,
    input logic [31:0] o_hit_total
);

    // a taken request keeps the block busy the next cycle
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy) else $error("not busy after request");

    // result shows only as the block frees up
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy && $past(busy)) else $error("result without work");

    // decision bit only on a hit
    a_dec_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_hit |-> !o_decision_out) else $error("decision without hit");

    // a hit is always counted
    a_hit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_hit |-> o_hit_total != 32'd0) else $error("hit not counted");

endmodule

bind ttl_hash_decision_cache ttlhc_checker u_ttlhc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_valid        (o_valid),
    .o_hit          (o_hit),
    .o_decision_out (o_decision_out),
    .o_hit_total    (o_hit_total)
);
